// File: rtl/core/bpts_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and helpers for the beatty priority task selector
package bpts_pkg;

  localparam int MAX_TASKS = 16;
  localparam int TASK_W    = 4;
  localparam int PRIO_W    = 31;
  localparam int MASK_W    = 16;
  localparam int CNT_W     = 32;
  localparam int ALPHA_W   = 32;
  localparam int PROD_W    = CNT_W + ALPHA_W;
  localparam int FRAC_W    = 16;
  localparam int BEATTY_W  = 48;
  localparam int NR_W      = $clog2(MAX_TASKS + 1);
  localparam int DIV_CNT_W = $clog2(BEATTY_W);
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  localparam logic [ALPHA_W-1:0]   ALPHA_RESET   = 32'd106039;
  localparam logic [CNT_W-1:0]     CNT_SAT       = '1;
  localparam logic [PADDR_W-3:0]   REG_ALPHA_IDX = '0;

  typedef enum logic [1:0] {
    OP_SET_PRIO = 2'd0,
    OP_SELECT   = 2'd1,
    OP_CLR_STEP = 2'd2,
    OP_READ_CNT = 2'd3
  } opcode_t;

  typedef struct packed {
    opcode_t              opcode;
    logic [TASK_W-1:0]    task_index;
    logic [PRIO_W-1:0]    priority_value;
    logic [MASK_W-1:0]    ready_mask;
  } cmd_t;

  typedef struct packed {
    logic                 found;
    logic [TASK_W-1:0]    chosen_task;
    logic [BEATTY_W-1:0]  beatty_number;
    logic [CNT_W-1:0]     task_count;
    logic [CNT_W-1:0]     all_count;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic mul;
    logic div_step;
    logic scan_step;
    logic finish;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic skip_search;
    logic div_last;
    logic scan_hit;
    logic rsp_free;
  } sts_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_SAT) ? v : v + CNT_W'(1);
  endfunction

endpackage

// File: rtl/core/bpts_ctrl.sv
`timescale 1ns / 1ps
// sequencing state machine for the beatty priority task selector
module bpts_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  bpts_pkg::sts_t sts,
  output bpts_pkg::ctl_t ctl
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_MUL    = 5'b00010,
    ST_DIV    = 5'b00100,
    ST_SCAN   = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    ctl        = '0;
    state_next = state;
    cmd_stall  = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          ctl.load   = 1'b1;
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        ctl.mul    = 1'b1;
        state_next = sts.skip_search ? ST_FINISH : ST_DIV;
      end
      ST_DIV: begin
        ctl.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.scan_hit) begin
          state_next = ST_FINISH;
        end else begin
          ctl.scan_step = 1'b1;
        end
      end
      ST_FINISH: begin
        if (sts.rsp_free) begin
          ctl.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/core/bpts_datapath.sv
`timescale 1ns / 1ps
// tables, multiplier, serial modulo, rank scan and output register
module bpts_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [bpts_pkg::ALPHA_W-1:0]     alpha,
  input  bpts_pkg::cmd_t                   cmd,
  input  bpts_pkg::ctl_t                   ctl,
  output bpts_pkg::sts_t                   sts,
  output logic                             rsp_valid,
  input  logic                             rsp_stall,
  output bpts_pkg::rsp_t                   rsp
);

  bpts_pkg::cmd_t                     cmd_r;
  logic [bpts_pkg::NR_W-1:0]          nready;
  logic [bpts_pkg::BEATTY_W-1:0]      beatty;
  logic [bpts_pkg::BEATTY_W-1:0]      div_sh;
  logic [bpts_pkg::DIV_CNT_W-1:0]     div_cnt;
  logic [bpts_pkg::NR_W-1:0]          rem;
  logic [bpts_pkg::TASK_W-1:0]        scan_idx;
  logic [bpts_pkg::CNT_W-1:0]         step_counter;
  logic [bpts_pkg::CNT_W-1:0]         total_count;
  logic [bpts_pkg::PRIO_W-1:0]        prio_table [bpts_pkg::MAX_TASKS];
  logic [bpts_pkg::CNT_W-1:0]         task_counts [bpts_pkg::MAX_TASKS];

  logic [bpts_pkg::PROD_W-1:0]        product;
  logic [bpts_pkg::NR_W:0]            trial;
  logic                               trial_ge;
  logic [bpts_pkg::NR_W-1:0]          rem_next;
  logic [bpts_pkg::PRIO_W-1:0]        cur_prio;
  logic [bpts_pkg::MAX_TASKS-1:0]     ahead;
  logic [bpts_pkg::NR_W-1:0]          rank;
  logic                               is_select;
  logic                               found;
  logic [bpts_pkg::TASK_W-1:0]        cnt_addr;
  logic [bpts_pkg::CNT_W-1:0]         cnt_rd;
  logic [bpts_pkg::CNT_W-1:0]         cnt_inc;
  logic [bpts_pkg::CNT_W-1:0]         total_inc;
  bpts_pkg::rsp_t                     rsp_next;

  assign product = bpts_pkg::PROD_W'(step_counter) * bpts_pkg::PROD_W'(alpha);

  // one restoring step of beatty mod nready
  assign trial    = {rem, div_sh[bpts_pkg::BEATTY_W-1]};
  assign trial_ge = (trial >= {1'b0, nready});
  assign rem_next = trial_ge ? bpts_pkg::NR_W'(trial - {1'b0, nready})
                             : trial[bpts_pkg::NR_W-1:0];

  // rank of the task under scan: ready tasks ordered ahead of it
  always_comb begin
    cur_prio = prio_table[scan_idx];
    ahead    = '0;
    for (int j = 0; j < bpts_pkg::MAX_TASKS; j++) begin
      ahead[j] = cmd_r.ready_mask[j] &&
                 ((prio_table[j] > cur_prio) ||
                  ((prio_table[j] == cur_prio) &&
                   (bpts_pkg::TASK_W'(j) < scan_idx)));
    end
    rank = bpts_pkg::NR_W'($countones(ahead));
  end

  assign is_select = (cmd_r.opcode == bpts_pkg::OP_SELECT);
  assign found     = is_select && (nready != '0);
  assign cnt_addr  = is_select ? scan_idx : cmd_r.task_index;
  assign cnt_rd    = task_counts[cnt_addr];
  assign cnt_inc   = bpts_pkg::sat_inc(cnt_rd);
  assign total_inc = bpts_pkg::sat_inc(total_count);

  always_comb begin
    rsp_next.found         = found;
    rsp_next.chosen_task   = found ? scan_idx : '0;
    rsp_next.beatty_number = is_select ? beatty : '0;
    if (found) begin
      rsp_next.task_count = cnt_inc;
    end else if (cmd_r.opcode == bpts_pkg::OP_READ_CNT) begin
      rsp_next.task_count = cnt_rd;
    end else begin
      rsp_next.task_count = '0;
    end
    rsp_next.all_count = found ? total_inc : total_count;
  end

  assign sts.skip_search = !is_select || (nready == '0);
  assign sts.div_last    = (div_cnt == bpts_pkg::DIV_CNT_W'(bpts_pkg::BEATTY_W - 1));
  assign sts.scan_hit    = cmd_r.ready_mask[scan_idx] && (rank == rem);
  assign sts.rsp_free    = !rsp_valid || !rsp_stall;

  // working registers of the current item
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r    <= cmd;
      nready   <= bpts_pkg::NR_W'($countones(cmd.ready_mask));
      scan_idx <= '0;
    end
    if (ctl.mul) begin
      beatty  <= product[bpts_pkg::FRAC_W +: bpts_pkg::BEATTY_W];
      div_sh  <= product[bpts_pkg::FRAC_W +: bpts_pkg::BEATTY_W];
      div_cnt <= '0;
      rem     <= '0;
    end
    if (ctl.div_step) begin
      div_sh  <= div_sh << 1;
      div_cnt <= div_cnt + bpts_pkg::DIV_CNT_W'(1);
      rem     <= rem_next;
    end
    if (ctl.scan_step) begin
      scan_idx <= scan_idx + bpts_pkg::TASK_W'(1);
    end
    if (ctl.finish) begin
      rsp <= rsp_next;
    end
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      step_counter <= '0;
      total_count  <= '0;
      for (int i = 0; i < bpts_pkg::MAX_TASKS; i++) begin
        prio_table[i]  <= '0;
        task_counts[i] <= '0;
      end
    end else if (ctl.finish) begin
      case (cmd_r.opcode)
        bpts_pkg::OP_SET_PRIO: begin
          prio_table[cmd_r.task_index] <= cmd_r.priority_value;
        end
        bpts_pkg::OP_SELECT: begin
          if (found) begin
            step_counter          <= step_counter + bpts_pkg::CNT_W'(1);
            task_counts[scan_idx] <= cnt_inc;
            total_count           <= total_inc;
          end
        end
        bpts_pkg::OP_CLR_STEP: begin
          step_counter <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctl.finish) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

endmodule

// File: rtl/core/beatty_priority_task_selector.sv
`timescale 1ns / 1ps
// Beatty priority task selector top level: apb register, controller and datapath.
// One command beat at a time. A select with at least one ready task runs
// from accept to the result beat through the 32x32 multiply that forms B,
// the one-bit-per-cycle serial modulo of B by the ready count, then a scan
// that tests one task's rank per cycle until it hits, and the load of the
// result. A select with no ready task and the other opcodes skip the modulo
// and the scan. The result sits in an output register, so a new command is
// taken while an earlier result is still stalled.
// alpha_multiplier is at byte address 0; write it only while the block is idle.
module beatty_priority_task_selector (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cmd_valid,
  output logic                           cmd_stall,
  input  bpts_pkg::cmd_t                 cmd,
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output bpts_pkg::rsp_t                 rsp,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bpts_pkg::PADDR_W-1:0]   paddr,
  input  logic [bpts_pkg::PDATA_W-1:0]   pwdata,
  output logic [bpts_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);

  logic [bpts_pkg::ALPHA_W-1:0] alpha;
  logic                         alpha_sel;
  bpts_pkg::ctl_t               ctl;
  bpts_pkg::sts_t               sts;

  assign pready    = 1'b1;
  assign alpha_sel = (paddr[bpts_pkg::PADDR_W-1:2] == bpts_pkg::REG_ALPHA_IDX);
  assign prdata    = alpha_sel ? alpha : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha <= bpts_pkg::ALPHA_RESET;
    end else if (psel && penable && pwrite && pready && alpha_sel) begin
      alpha <= pwdata;
    end
  end

  bpts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .sts       (sts),
    .ctl       (ctl)
  );

  bpts_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .alpha     (alpha),
    .cmd       (cmd),
    .ctl       (ctl),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

`ifndef SYNTH
  // one beat in flight: busy right after an accept
  assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall |=> cmd_stall)
    else $error("command accepted while previous one in flight");

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.found |-> rsp.all_count != '0)
    else $error("selection reported with zero total");

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.found |-> rsp.chosen_task == '0)
    else $error("task index reported without a selection");
`endif

endmodule
